// ===== rtl/core/midi_cc_binding_soft_takeover_assert.svh =====
// Assertion macros shared by the binding table RTL.
`ifndef MIDI_CC_BINDING_SOFT_TAKEOVER_ASSERT_SVH
`define MIDI_CC_BINDING_SOFT_TAKEOVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mcst assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mcst assertion failed");

`endif

// ===== rtl/core/mcst_pkg.sv =====
// Types and constants of the CC binding table with soft takeover.
`default_nettype none

package mcst_pkg;

	typedef enum logic [2:0] {
		OP_CC         = 3'd0,
		OP_SET_TARGET = 3'd1,
		OP_LEARN      = 3'd2,
		OP_CANCEL     = 3'd3,
		OP_CLEAR_SLOT = 3'd4,
		OP_CLEAR_ALL  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	// register index as decoded from paddr[2]
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	localparam logic       ENABLE_RST = 1'b1;
	localparam logic [6:0] THRESH_RST = 7'd3;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_DONE   = 1'b1;

	// table size limit set by the 4-bit slot field
	localparam int MAX_SLOTS = 16;

	typedef struct packed {
		logic latch;      // capture input item
		logic exec;       // apply non-scan op
		logic scan_step;  // evaluate one slot
		logic load_done;  // load done result
	} cmd_t;

	typedef struct packed {
		logic go_scan;    // cc message with learning not armed
		logic scan_last;  // scan counter on last slot
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/midi_cc_binding_soft_takeover.sv =====
// Top level: MIDI CC binding table with soft-takeover pickup.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser op, tdata slot/cc/value/target
//  m_axis    out  m_axis_tvalid/tready      tuser kind, tdata slot/value/consumed, tlast
//  apb       in   psel/penable, pready=1    paddr[2] selects enable or threshold
//
// A cc message without learning scans min(NUM_SLOTS,16) slots: the scan counter
// evaluates one slot per cycle while the output has room; other ops execute once.
// Reset clears bindings, waiting flags and learning at once; no clearing pass.
// A stalled output register holds the scan; input is taken only between items,
// while the previous done result may still wait on m_axis.
`default_nettype none

`include "midi_cc_binding_soft_takeover_assert.svh"

module midi_cc_binding_soft_takeover #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: param_slot[3:0], cc_number[10:4], cc_value[17:11], target_value[24:18]
	input  wire logic [31:0] s_axis_tdata,
	// tuser: op[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: update_slot[3:0], update_value[10:4], consumed[11]
	output logic      [15:0] m_axis_tdata,
	// tuser: kind[0]
	output logic             m_axis_tuser,
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	mcst_pkg::cmd_t cmd;
	mcst_pkg::sts_t sts;
	logic           cfg_enable;
	logic [6:0]     cfg_thresh;
	logic [3:0]     out_slot;
	logic [6:0]     out_value;
	logic           out_consumed;

	mcst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.enable  (cfg_enable),
		.thresh  (cfg_thresh)
	);

	mcst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcst_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_op            (s_axis_tuser),
		.in_param_slot    (s_axis_tdata[3:0]),
		.in_cc_number     (s_axis_tdata[10:4]),
		.in_cc_value      (s_axis_tdata[17:11]),
		.in_target_value  (s_axis_tdata[24:18]),
		.cfg_enable       (cfg_enable),
		.cfg_thresh       (cfg_thresh),
		.out_ready        (m_axis_tready),
		.out_valid        (m_axis_tvalid),
		.out_kind         (m_axis_tuser),
		.out_update_slot  (out_slot),
		.out_update_value (out_value),
		.out_consumed     (out_consumed),
		.out_last         (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, out_consumed, out_value, out_slot};

	`MCST_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`MCST_ASSERT_NOW(a_no_scan_when_ready, clk, arst_n, s_axis_tready, !cmd.scan_step && !cmd.exec)
	`MCST_ASSERT_NOW(a_scan_needs_room, clk, arst_n, cmd.scan_step || cmd.exec, sts.out_free)
	`MCST_ASSERT_NOW(a_done_needs_room, clk, arst_n, cmd.load_done, sts.out_free)

endmodule

`default_nettype wire

// ===== rtl/core/mcst_cfg.sv =====
// APB configuration registers: soft takeover enable and catch-up threshold.
`default_nettype none

module mcst_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic             enable,
	output logic      [6:0]  thresh
);

	logic       enable_q;
	logic [6:0] thresh_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	// word decode on paddr[2]; byte offset bits alias
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= mcst_pkg::ENABLE_RST;
			thresh_q <= mcst_pkg::THRESH_RST;
		end else if (wr) begin
			if (paddr[2] == mcst_pkg::REG_ENABLE) begin
				enable_q <= pwdata[0];
			end else begin
				thresh_q <= pwdata[6:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == mcst_pkg::REG_THRESH) begin
			prdata = {25'd0, thresh_q};
		end else begin
			prdata = {31'd0, enable_q};
		end
	end

	assign enable = enable_q;
	assign thresh = thresh_q;

endmodule

`default_nettype wire

// ===== rtl/core/mcst_dp.sv =====
// Datapath: binding table, slot scan evaluation and output register.
`default_nettype none

module mcst_dp #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mcst_pkg::cmd_t cmd,
	output mcst_pkg::sts_t     sts,
	input  wire logic [2:0]    in_op,
	input  wire logic [3:0]    in_param_slot,
	input  wire logic [6:0]    in_cc_number,
	input  wire logic [6:0]    in_cc_value,
	input  wire logic [6:0]    in_target_value,
	input  wire logic          cfg_enable,
	input  wire logic [6:0]    cfg_thresh,
	input  wire logic          out_ready,
	output logic               out_valid,
	output logic               out_kind,
	output logic      [3:0]    out_update_slot,
	output logic      [6:0]    out_update_value,
	output logic               out_consumed,
	output logic               out_last
);

	localparam int NS = (NUM_SLOTS < mcst_pkg::MAX_SLOTS) ? NUM_SLOTS : mcst_pkg::MAX_SLOTS;
	localparam int IW = (NS > 1) ? $clog2(NS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NS - 1);
	localparam logic [6:0]    NS_W     = 7'(NS);

	logic [NS-1:0] valid_q;
	logic [NS-1:0] waiting_q;
	logic [6:0]    ccnum_q   [NS];
	logic [6:0]    lastpos_q [NS];
	logic [6:0]    target_q  [NS];
	logic          learn_active_q;
	logic [3:0]    learn_slot_q;
	logic [IW-1:0] cnt_q;
	logic          consumed_q;

	mcst_pkg::op_t op_q;
	logic [3:0]    ps_q;
	logic [6:0]    ccn_q;
	logic [6:0]    ccv_q;
	logic [6:0]    tgt_q;

	logic          out_valid_q;
	logic          out_kind_q;
	logic [3:0]    out_slot_q;
	logic [6:0]    out_value_q;
	logic          out_consumed_q;
	logic          out_last_q;

	logic          slot_ok;
	logic          learn_ok;
	logic [IW-1:0] ps_idx;
	logic [IW-1:0] ls_idx;
	logic          hit;
	logic          gated;
	logic [6:0]    prev;
	logic [6:0]    tpos;
	logic [6:0]    delta;
	logic          near;
	logic          crossed;
	logic          lock;
	logic          scan_emit;
	logic          learn_emit;
	logic          set_ok;

	assign slot_ok  = ({3'd0, ps_q} < NS_W);
	assign learn_ok = ({3'd0, learn_slot_q} < NS_W);
	assign ps_idx   = ps_q[IW-1:0];
	assign ls_idx   = learn_slot_q[IW-1:0];
	assign set_ok   = cfg_enable && slot_ok && valid_q[ps_idx];

	// per-slot pickup evaluation at the scan pointer
	always_comb begin
		hit     = valid_q[cnt_q] && (ccnum_q[cnt_q] == ccn_q);
		gated   = cfg_enable && waiting_q[cnt_q];
		prev    = lastpos_q[cnt_q];
		tpos    = target_q[cnt_q];
		delta   = (ccv_q >= tpos) ? (ccv_q - tpos) : (tpos - ccv_q);
		near    = delta < cfg_thresh;
		crossed = ((prev <= tpos) && (ccv_q >= tpos)) || ((prev >= tpos) && (ccv_q <= tpos));
		lock    = near || crossed;
	end

	assign scan_emit  = cmd.scan_step && hit && (!gated || lock);
	assign learn_emit = cmd.exec && (op_q == mcst_pkg::OP_CC) && learn_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			waiting_q      <= '0;
			learn_active_q <= 1'b0;
			learn_slot_q   <= 4'd0;
			cnt_q          <= '0;
			consumed_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.latch) begin
				cnt_q      <= '0;
				consumed_q <= 1'b0;
			end
			if (cmd.exec) begin
				case (op_q)
					mcst_pkg::OP_CC: begin
						// only reached with learning armed
						if (learn_ok) begin
							valid_q[ls_idx]   <= 1'b1;
							waiting_q[ls_idx] <= 1'b0;
						end
						learn_active_q <= 1'b0;
						consumed_q     <= 1'b1;
					end
					mcst_pkg::OP_SET_TARGET: begin
						if (set_ok) begin
							waiting_q[ps_idx] <= 1'b1;
						end
					end
					mcst_pkg::OP_LEARN: begin
						if (slot_ok) begin
							learn_active_q <= 1'b1;
							learn_slot_q   <= ps_q;
						end
					end
					mcst_pkg::OP_CANCEL: begin
						learn_active_q <= 1'b0;
					end
					mcst_pkg::OP_CLEAR_SLOT: begin
						if (slot_ok) begin
							valid_q[ps_idx]   <= 1'b0;
							waiting_q[ps_idx] <= 1'b0;
						end
					end
					mcst_pkg::OP_CLEAR_ALL: begin
						valid_q   <= '0;
						waiting_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan_step) begin
				if (hit) begin
					consumed_q <= 1'b1;
				end
				if (hit && gated && lock) begin
					waiting_q[cnt_q] <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			if (learn_emit || scan_emit || cmd.load_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= mcst_pkg::op_t'(in_op);
			ps_q  <= in_param_slot;
			ccn_q <= in_cc_number;
			ccv_q <= in_cc_value;
			tgt_q <= in_target_value;
		end
		if (learn_emit) begin
			ccnum_q[ls_idx]   <= ccn_q;
			lastpos_q[ls_idx] <= ccv_q;
		end
		if (cmd.exec && (op_q == mcst_pkg::OP_SET_TARGET) && set_ok) begin
			target_q[ps_idx] <= tgt_q;
		end
		if (cmd.scan_step && hit) begin
			lastpos_q[cnt_q] <= ccv_q;
		end
		if (learn_emit) begin
			out_kind_q     <= mcst_pkg::KIND_UPDATE;
			out_slot_q     <= learn_slot_q;
			out_value_q    <= ccv_q;
			out_consumed_q <= 1'b0;
			out_last_q     <= 1'b0;
		end else if (scan_emit) begin
			out_kind_q     <= mcst_pkg::KIND_UPDATE;
			out_slot_q     <= 4'(cnt_q);
			out_value_q    <= ccv_q;
			out_consumed_q <= 1'b0;
			out_last_q     <= 1'b0;
		end else if (cmd.load_done) begin
			out_kind_q     <= mcst_pkg::KIND_DONE;
			out_slot_q     <= 4'd0;
			out_value_q    <= 7'd0;
			out_consumed_q <= consumed_q;
			out_last_q     <= 1'b1;
		end
	end

	always_comb begin
		sts.go_scan   = (op_q == mcst_pkg::OP_CC) && !learn_active_q;
		sts.scan_last = (cnt_q == LAST_IDX);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid        = out_valid_q;
	assign out_kind         = out_kind_q;
	assign out_update_slot  = out_slot_q;
	assign out_update_value = out_value_q;
	assign out_consumed     = out_consumed_q;
	assign out_last         = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/mcst_ctrl.sv =====
// Controller: sequences capture, op execution, slot scan and done result.
`default_nettype none

module mcst_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mcst_pkg::sts_t sts,
	output mcst_pkg::cmd_t      cmd
);

	mcst_pkg::state_t state_q;
	mcst_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mcst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = mcst_pkg::ST_EXEC;
				end
			end
			mcst_pkg::ST_EXEC: begin
				if (sts.go_scan) begin
					state_d = mcst_pkg::ST_SCAN;
				end else if (sts.out_free) begin
					// learn may emit an update, so wait for the output
					cmd.exec = 1'b1;
					state_d  = mcst_pkg::ST_DONE;
				end
			end
			mcst_pkg::ST_SCAN: begin
				if (sts.out_free) begin
					cmd.scan_step = 1'b1;
					if (sts.scan_last) begin
						state_d = mcst_pkg::ST_DONE;
					end
				end
			end
			mcst_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_done = 1'b1;
					state_d       = mcst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mcst_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== verif/mcst_binding_checker.sv =====
// Checker for the CC binding table: mirrors the bindings and compares every result item.
module mcst_binding_checker
	import mcst_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [31:0] s_data,
	input  logic [2:0]  s_user,
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [15:0] m_data,
	input  logic        m_user,
	input  logic        m_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          results_owed
);

	typedef struct packed {
		logic       kind;
		logic [3:0] slot;
		logic [6:0] value;
		logic       consumed;
		logic       last;
	} result_t;

	result_t              owed_q[$];
	result_t              want;
	logic [MAX_SLOTS-1:0] bound;
	logic [MAX_SLOTS-1:0] waiting;
	logic [6:0]           bind_cc [MAX_SLOTS];
	logic [7:0]           last_pos [MAX_SLOTS];
	logic [6:0]           target [MAX_SLOTS];
	logic                 learning;
	logic [3:0]           learn_slot;
	logic                 takeover_en;
	logic [6:0]           catchup;
	int                   errors;
	int                   k;

	task automatic owe(input logic kind, input logic [3:0] slot, input logic [6:0] value,
			input logic consumed, input logic last);
		result_t r;
		r.kind = kind;
		r.slot = slot;
		r.value = value;
		r.consumed = consumed;
		r.last = last;
		owed_q.push_back(r);
	endtask

	// Update the mirrored table for one accepted item and queue the results it owes.
	task automatic apply_message(input logic [2:0] op, input logic [3:0] ps,
			input logic [6:0] ccn, input logic [6:0] ccv, input logic [6:0] tgt);
		int   i;
		int   prev;
		int   cur;
		int   t;
		int   delta;
		logic hit;
		logic near;
		logic crossed;
		logic slot_ok;
		hit = 1'b0;
		slot_ok = int'(ps) < NUM_SLOTS;
		case (op)
		OP_CC: begin
			if (learning) begin
				if (int'(learn_slot) < NUM_SLOTS) begin
					bound[learn_slot] = 1'b1;
					bind_cc[learn_slot] = ccn;
					waiting[learn_slot] = 1'b0;
					last_pos[learn_slot] = {1'b0, ccv};
					owe(KIND_UPDATE, learn_slot, ccv, 1'b0, 1'b0);
				end
				learning = 1'b0;
				hit = 1'b1;
			end else begin
				for (i = 0; i < NUM_SLOTS && i < MAX_SLOTS; i++) begin
					if (bound[i] && bind_cc[i] == ccn) begin
						prev = int'(last_pos[i]);
						last_pos[i] = {1'b0, ccv};
						hit = 1'b1;
						if (takeover_en && waiting[i]) begin
							cur = int'(ccv);
							t = int'(target[i]);
							delta = (cur > t) ? cur - t : t - cur;
							near = delta < int'(catchup);
							// landing on the target counts as crossing it
							crossed = (prev <= t && cur >= t) || (prev >= t && cur <= t);
							if (near || crossed)
								waiting[i] = 1'b0;
						end
						if (!(takeover_en && waiting[i]))
							owe(KIND_UPDATE, i[3:0], ccv, 1'b0, 1'b0);
					end
				end
			end
		end
		OP_SET_TARGET: begin
			if (takeover_en && slot_ok && bound[ps]) begin
				target[ps] = tgt;
				waiting[ps] = 1'b1;
			end
		end
		OP_LEARN: begin
			if (slot_ok) begin
				learning = 1'b1;
				learn_slot = ps;
			end
		end
		OP_CANCEL: learning = 1'b0;
		OP_CLEAR_SLOT: begin
			if (slot_ok) begin
				bound[ps] = 1'b0;
				waiting[ps] = 1'b0;
			end
		end
		OP_CLEAR_ALL: begin
			bound = '0;
			waiting = '0;
		end
		default: ;
		endcase
		owe(KIND_DONE, 4'd0, 7'd0, hit, 1'b1);
	endtask

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			errors++;
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			bound = '0;
			waiting = '0;
			for (k = 0; k < MAX_SLOTS; k++) begin
				bind_cc[k] = '0;
				last_pos[k] = '0;
				target[k] = '0;
			end
			learning = 1'b0;
			learn_slot = '0;
			takeover_en = ENABLE_RST;
			catchup = THRESH_RST;
			errors = 0;
			fail_count <= 0;
			results_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ENABLE)
					takeover_en = pwdata[0];
				else
					catchup = pwdata[6:0];
			end
			if (m_valid && m_ready) begin
				if (owed_q.size() == 0) begin
					errors++;
					$error("result item with nothing owed: kind %0d slot %0d value %0d",
						m_user, m_data[3:0], m_data[10:4]);
				end else begin
					want = owed_q.pop_front();
					check_field("kind", want.kind, m_user);
					check_field("update_slot", want.slot, m_data[3:0]);
					check_field("update_value", want.value, m_data[10:4]);
					check_field("consumed", want.consumed, m_data[11]);
					check_field("last", want.last, m_last);
				end
			end
			if (s_valid && s_ready)
				apply_message(s_user, s_data[3:0], s_data[10:4], s_data[17:11], s_data[24:18]);
			fail_count <= errors;
			results_owed <= owed_q.size();
		end
	end

endmodule

// ===== verif/midi_cc_binding_soft_takeover_tb.sv =====
// Testbench top: drives messages and register writes into the CC binding table.
module midi_cc_binding_soft_takeover_tb;
	import mcst_pkg::*;

	localparam int         SLOTS        = 16;
	localparam int         STALL_LIMIT  = 5000;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         ITEMS_PHASE  = 26;
	localparam int         NUM_PHASES   = 6;
	localparam logic [2:0] OP_UNUSED6   = 3'd6;
	localparam logic [2:0] OP_UNUSED7   = 3'd7;
	localparam logic [2:0] ADDR_ENABLE  = {REG_ENABLE, 2'b00};
	localparam logic [2:0] ADDR_THRESH  = {REG_THRESH, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// tdata: param_slot, cc_number, cc_value, target_value, zero pad
	logic [31:0] s_axis_tdata = '0;
	// tuser: op
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tdata: update_slot, update_value, consumed, zero pad
	logic [15:0] m_axis_tdata;
	// tuser: kind
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          results_owed;
	int          tx_idle_pct = 7;
	int          rx_idle_pct = 76;
	logic        hold_req = 1'b0;
	logic        hold_taken;
	int          hold_left;
	int          quiet_cycles = 0;
	logic [6:0]  cc_pool [4];
	logic        en_set [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	int          thr_set [NUM_PHASES] = '{3, 0, 127, 127, 0, -1};
	int          ph;
	int          n;
	logic [3:0]  arm_slot;

	midi_cc_binding_soft_takeover #(.NUM_SLOTS(SLOTS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	mcst_binding_checker #(.NUM_SLOTS(SLOTS)) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.s_data      (s_axis_tdata),
		.s_user      (s_axis_tuser),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_data      (m_axis_tdata),
		.m_user      (m_axis_tuser),
		.m_last      (m_axis_tlast),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.results_owed(results_owed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_taken <= 1'b0;
			hold_left <= 0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable && pready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_item(input logic [2:0] op, input logic [3:0] slot, input logic [6:0] ccn,
			input logic [6:0] ccv, input logic [6:0] tgt);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 30)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {7'd0, tgt, ccv, ccn, slot};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [6:0] pick_cc();
		if ($urandom_range(9) < 8)
			return cc_pool[$urandom_range(3)];
		return 7'($urandom_range(127));
	endfunction

	// Mostly well-formed traffic on a few controller numbers, with some noise.
	task automatic send_random;
		int         pick;
		logic [3:0] slot;
		logic [6:0] ccn;
		pick = $urandom_range(99);
		slot = 4'($urandom_range(15));
		ccn = pick_cc();
		if (pick < 50)
			send_item(OP_CC, slot, ccn, 7'($urandom_range(127)), 7'($urandom_range(127)));
		else if (pick < 64)
			send_item(OP_SET_TARGET, slot, ccn, 7'($urandom_range(127)),
				7'($urandom_range(127)));
		else if (pick < 76) begin
			send_item(OP_LEARN, slot, ccn, 7'($urandom_range(127)), 7'($urandom_range(127)));
			if ($urandom_range(9) < 8)
				send_item(OP_CC, 4'($urandom_range(15)), pick_cc(), 7'($urandom_range(127)),
					7'($urandom_range(127)));
		end else if (pick < 81)
			send_item(OP_CANCEL, slot, ccn, 7'($urandom_range(127)), 7'($urandom_range(127)));
		else if (pick < 88)
			send_item(OP_CLEAR_SLOT, slot, ccn, 7'($urandom_range(127)),
				7'($urandom_range(127)));
		else if (pick < 91)
			send_item(OP_CLEAR_ALL, slot, ccn, 7'($urandom_range(127)), 7'($urandom_range(127)));
		else if (pick < 95)
			send_item(pick[0] ? OP_UNUSED7 : OP_UNUSED6, slot, ccn, 7'($urandom_range(127)),
				7'($urandom_range(127)));
		else
			send_item(OP_CC, slot, 7'($urandom_range(127)), 7'($urandom_range(127)),
				7'($urandom_range(127)));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values
		send_item(OP_CC, 4'd15, 7'd127, 7'd127, 7'd127);
		send_item(OP_LEARN, 4'd0, 7'd0, 7'd0, 7'd0);
		send_item(OP_CC, 4'd0, 7'd0, 7'd0, 7'd0);
		send_item(OP_LEARN, 4'd15, 7'd127, 7'd127, 7'd127);
		send_item(OP_CC, 4'd15, 7'd0, 7'd127, 7'd0);
		send_item(OP_CC, 4'd0, 7'd0, 7'd64, 7'd0);
		send_item(OP_SET_TARGET, 4'd0, 7'd0, 7'd0, 7'd127);
		send_item(OP_CC, 4'd0, 7'd0, 7'd10, 7'd0);      // slot 0 swallowed
		send_item(OP_CC, 4'd0, 7'd0, 7'd125, 7'd0);     // near the target
		send_item(OP_SET_TARGET, 4'd15, 7'd0, 7'd0, 7'd50);
		send_item(OP_CC, 4'd0, 7'd0, 7'd20, 7'd0);      // jumps across the target
		send_item(OP_SET_TARGET, 4'd7, 7'd0, 7'd0, 7'd5);
		send_item(OP_LEARN, 4'd3, 7'd0, 7'd0, 7'd0);
		send_item(OP_CANCEL, 4'd3, 7'd0, 7'd0, 7'd0);
		send_item(OP_CC, 4'd3, 7'd5, 7'd5, 7'd0);
		send_item(OP_CLEAR_SLOT, 4'd15, 7'd0, 7'd0, 7'd0);
		send_item(OP_CC, 4'd0, 7'd0, 7'd99, 7'd0);
		send_item(OP_LEARN, 4'd4, 7'd0, 7'd0, 7'd0);
		send_item(OP_CLEAR_SLOT, 4'd4, 7'd0, 7'd0, 7'd0); // learning stays armed
		send_item(OP_CC, 4'd0, 7'd9, 7'd9, 7'd0);
		send_item(OP_LEARN, 4'd0, 7'd0, 7'd0, 7'd0);     // relearn a bound slot
		send_item(OP_CC, 4'd0, 7'd9, 7'd1, 7'd0);
		send_item(OP_UNUSED6, 4'd15, 7'd127, 7'd127, 7'd127);
		send_item(OP_UNUSED7, 4'd0, 7'd0, 7'd0, 7'd0);
		send_item(OP_CC, 4'd0, 7'd9, 7'd50, 7'd0);
		send_item(OP_CLEAR_ALL, 4'd0, 7'd0, 7'd0, 7'd0);
		send_item(OP_CC, 4'd0, 7'd9, 7'd1, 7'd0);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			write_reg(ADDR_ENABLE, {31'd0, en_set[ph]});
			write_reg(ADDR_THRESH, (thr_set[ph] < 0) ? 32'($urandom_range(1, 20)) :
				32'(thr_set[ph]));
			if (ph == 2) begin
				tx_idle_pct = 76;
				rx_idle_pct <= 7;
			end else if (ph == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
				hold_req <= 1'b1;
			end
			for (n = 0; n < 4; n++)
				cc_pool[n] = 7'($urandom_range(127));
			// bind one slot and arm it, so waiting slots exist in every phase with takeover enabled
			arm_slot = 4'($urandom_range(15));
			send_item(OP_LEARN, arm_slot, 7'($urandom_range(127)), 7'($urandom_range(127)),
				7'($urandom_range(127)));
			send_item(OP_CC, 4'($urandom_range(15)), cc_pool[0], 7'($urandom_range(127)),
				7'($urandom_range(127)));
			send_item(OP_SET_TARGET, arm_slot, 7'($urandom_range(127)),
				7'($urandom_range(127)), 7'($urandom_range(127)));
			for (n = 0; n < ITEMS_PHASE; n++)
				send_random();
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
